### hw/rtl/qts_pkg.sv
// Package: item types, character codes and the per-byte parse function of the token splitter.
package qts_pkg;

   // Depth of the result list that one item can produce, and its count width.
   localparam int ListDepth = 6;
   localparam int ListCntW  = 3;

   // Result kinds.
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_TEND = 2'd1;
   localparam logic [1:0] KIND_MEND = 2'd2;

   // Token classes.
   localparam logic [1:0] CLS_PLAIN  = 2'd0;
   localparam logic [1:0] CLS_ARG    = 2'd1;
   localparam logic [1:0] CLS_HANDLE = 2'd2;

   // Character codes.
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LSQ    = 8'h5B;
   localparam logic [7:0] CH_RSQ    = 8'h5D;
   localparam logic [7:0] CH_LCURLY = 8'h7B;
   localparam logic [7:0] CH_RCURLY = 8'h7D;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_TILDE  = 8'h7E;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;

   // Group modes; the code doubles as the unclosed-group error code.
   typedef enum logic [2:0] {
      GRP_NONE   = 3'd0,
      GRP_SQ     = 3'd1,
      GRP_DQ     = 3'd2,
      GRP_SQUARE = 3'd3,
      GRP_CURLY  = 3'd4,
      GRP_TRI    = 3'd5
   } group_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [1:0] token_kind;
      logic [2:0] error_code;
      logic       run_last;
   } rsp_type;

   // Results produced by one item, in delivery order from entry 0.
   typedef struct packed {
      rsp_type [ListDepth-1:0] entry;
      logic    [ListCntW-1:0]  count;
   } rsp_list_type;

   typedef struct packed {
      group_type  group;
      logic       token_open;
      logic [1:0] token_class;
   } parse_state_type;

   typedef struct packed {
      logic            emit;
      rsp_type         item;
      parse_state_type st;
   } consume_type;

   function automatic rsp_type make_byte(logic [7:0] c);
      rsp_type r;
      r           = '0;
      r.kind      = KIND_BYTE;
      r.data_byte = c;
      return r;
   endfunction

   function automatic rsp_type make_tend(logic [1:0] cls);
      rsp_type r;
      r            = '0;
      r.kind       = KIND_TEND;
      r.token_kind = cls;
      return r;
   endfunction

   function automatic rsp_type make_mend(logic [2:0] err);
      rsp_type r;
      r            = '0;
      r.kind       = KIND_MEND;
      r.error_code = err;
      return r;
   endfunction

   // Process one message byte c, with lookahead nx valid when has_next.
   function automatic consume_type consume(parse_state_type st, logic [7:0] c,
                                           logic has_next, logic [7:0] nx);
      consume_type res;
      logic        do_push;
      logic        do_end;
      res     = '0;
      res.st  = st;
      do_push = 1'b0;
      do_end  = 1'b0;
      unique case (st.group)
         GRP_SQ: begin
            if (c == CH_SQUOTE) res.st.group = GRP_NONE;
            else do_push = 1'b1;
         end
         GRP_DQ: begin
            if (c == CH_DQUOTE) res.st.group = GRP_NONE;
            else do_push = 1'b1;
         end
         GRP_SQUARE: begin
            do_push = 1'b1;
            if (c == CH_RSQ) res.st.group = GRP_NONE;
         end
         GRP_CURLY: begin
            do_push = 1'b1;
            if (c == CH_RCURLY) res.st.group = GRP_NONE;
         end
         GRP_TRI: begin
            do_push = 1'b1;
            if (c == CH_GT && has_next && nx == CH_GT) res.st.group = GRP_NONE;
         end
         default: begin
            // outside any group
            case (c)
               CH_SPACE:  do_end = 1'b1;
               CH_DQUOTE: res.st.group = GRP_DQ;
               CH_SQUOTE: res.st.group = GRP_SQ;
               CH_LSQ: begin
                  do_push      = 1'b1;
                  res.st.group = GRP_SQUARE;
               end
               CH_LCURLY: begin
                  do_push      = 1'b1;
                  res.st.group = GRP_CURLY;
               end
               CH_EQUAL: begin
                  do_push            = 1'b1;
                  res.st.token_class = CLS_ARG;
               end
               CH_TILDE: begin
                  do_push = 1'b1;
                  if (!st.token_open) res.st.token_class = CLS_HANDLE;
               end
               CH_LT: begin
                  do_push = 1'b1;
                  if (has_next && nx == CH_LT) res.st.group = GRP_TRI;
               end
               default: do_push = 1'b1;
            endcase
         end
      endcase
      if (do_push) begin
         res.emit          = 1'b1;
         res.item          = make_byte(c);
         res.st.token_open = 1'b1;
      end else if (do_end && st.token_open) begin
         res.emit           = 1'b1;
         res.item           = make_tend(res.st.token_class);
         res.st.token_open  = 1'b0;
         res.st.token_class = CLS_PLAIN;
      end
      return res;
   endfunction

endpackage

### hw/rtl/qts_core.sv
// Parser core: parse state, held-back byte and expansion of one item into its result list.
module qts_core import qts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         move,
   input  req_type      item,
   output rsp_list_type list
);

   parse_state_type state_ff, state_in;
   logic [7:0]      held_ff, held_in;
   logic            held_valid_ff, held_valid_in;

   always_comb begin
      parse_state_type      st;
      consume_type          r;
      logic [ListCntW-1:0]  n;
      logic [2:0]           err;
      st            = state_ff;
      r             = '0;
      n             = '0;
      list          = '0;
      err           = '0;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      state_in      = state_ff;

      // finish the held byte now that its follower is known
      if (held_valid_ff) begin
         r  = consume(st, held_ff, 1'b1, item.ch);
         st = r.st;
         if (r.emit) begin
            list.entry[n] = r.item;
            n             = n + ListCntW'(1);
         end
      end

      if (item.end_of_message) begin
         r  = consume(st, item.ch, 1'b0, 8'h00);
         st = r.st;
         if (r.emit) begin
            list.entry[n] = r.item;
            n             = n + ListCntW'(1);
         end
         err = st.group;
         // append the missing closer of a kept group
         case (st.group)
            GRP_SQUARE: begin
               list.entry[n] = make_byte(CH_RSQ);
               n             = n + ListCntW'(1);
               st.token_open = 1'b1;
            end
            GRP_CURLY: begin
               list.entry[n] = make_byte(CH_RCURLY);
               n             = n + ListCntW'(1);
               st.token_open = 1'b1;
            end
            GRP_TRI: begin
               list.entry[n] = make_byte(CH_GT);
               n             = n + ListCntW'(1);
               list.entry[n] = make_byte(CH_GT);
               n             = n + ListCntW'(1);
               st.token_open = 1'b1;
            end
            default: ;
         endcase
         if (st.token_open) begin
            list.entry[n] = make_tend(st.token_class);
            n             = n + ListCntW'(1);
         end
         list.entry[n] = make_mend(err);
         n             = n + ListCntW'(1);
         state_in      = '{group: GRP_NONE, token_open: 1'b0, token_class: CLS_PLAIN};
         held_valid_in = 1'b0;
      end else begin
         state_in      = st;
         held_in       = item.ch;
         held_valid_in = 1'b1;
      end

      if (n != '0) list.entry[n - ListCntW'(1)].run_last = 1'b1;
      list.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '{group: GRP_NONE, token_open: 1'b0, token_class: CLS_PLAIN};
         held_valid_ff <= 1'b0;
      end else if (move) begin
         state_ff      <= state_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) held_ff <= held_in;
   end

   // only a message end can produce more than one result
   a_single_unless_end: assert property (@(posedge clock) disable iff (reset)
      move && !item.end_of_message |-> list.count <= ListCntW'(1))
      else $error("more than one result for a mid-message item");

   a_end_clears_hold: assert property (@(posedge clock) disable iff (reset)
      move && item.end_of_message |=> !held_valid_ff && !state_ff.token_open)
      else $error("state not cleared after message end");

   a_hold_after_byte: assert property (@(posedge clock) disable iff (reset)
      move && !item.end_of_message |=> held_valid_ff)
      else $error("byte not held back");

endmodule

### hw/rtl/qts_rsp_buf.sv
// Result buffer: holds one item's results, delivered one per cycle unless stalled.
module qts_rsp_buf import qts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_list_type list,
   output logic         free,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_item
);

   rsp_type [ListDepth-1:0] entries_ff;
   logic    [ListCntW-1:0]  count_ff;
   logic    [ListCntW-1:0]  ptr_ff, ptr_in;
   logic                    pop;
   logic                    on_last;

   assign rsp_valid = ptr_ff != count_ff;
   assign pop       = rsp_valid && !rsp_stall;
   assign on_last   = ptr_ff == count_ff - ListCntW'(1);
   assign free      = !rsp_valid || (pop && on_last);
   assign rsp_item  = (ptr_ff < ListCntW'(ListDepth)) ? entries_ff[ptr_ff] : '0;
   assign ptr_in    = load ? '0 : (pop ? ptr_ff + ListCntW'(1) : ptr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         ptr_ff <= ptr_in;
         if (load) count_ff <= list.count;
      end
   end

   always_ff @(posedge clock) begin
      if (load) entries_ff <= list.entry;
   end

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= count_ff && count_ff <= ListCntW'(ListDepth))
      else $error("read pointer beyond result count");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.run_last == on_last)
      else $error("last-result mark out of place");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("list loaded over undelivered results");

endmodule

### hw/rtl/quoted_token_splitter.sv
// Top level of the quoted token splitter: input skid register, parser core, result buffer.
//
//   port group   direction  payload    handshake
//   req_*        in         req_type   req_valid / req_stall
//   rsp_*        out        rsp_type   rsp_valid / rsp_stall
//
// An accepted item first lands in a one-entry input register, then moves into the parser
// core, which expands it combinationally into a list of up to six results held in the
// result buffer. Mid-message bytes yield at most one result, so they flow at one item per
// cycle while the result side does not stall. A message end yields up to six results,
// delivered at one per cycle unless stalled; the buffer drain is what sets the rate then.
// Reset is synchronous and clears the parse state, the held-byte flag, the input valid
// flag and the result buffer.
// A stall on the result side holds the buffer; the input register still takes one item.
module quoted_token_splitter import qts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic         in_valid_ff, in_valid_in;
   req_type      item_ff;
   logic         accept;
   logic         move;
   logic         buf_free;
   rsp_list_type list;

   // advance the held item into the core once the buffer can take its results
   assign move        = in_valid_ff && buf_free;
   assign req_stall   = in_valid_ff && !move;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !move);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // capture the item on accept; hold it otherwise
   always_ff @(posedge clock) begin
      if (accept) item_ff <= req_item;
   end

   qts_core u_core (
      .clock (clock),
      .reset (reset),
      .move  (move),
      .item  (item_ff),
      .list  (list)
   );

   qts_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (move),
      .list      (list),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
